FILE: design/d2dn_pkg.sv
// ----------------------------------------------------------------------------
// d2dn_pkg
// Shared types, constants and calendar tables for the date to day number
// pipeline.
// ----------------------------------------------------------------------------
package d2dn_pkg;

   // Fixed field widths of the request and response beats.
   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned DAY_W      = 5;
   localparam int unsigned COUNT_W    = 23;
   localparam int unsigned WEEKDAY_W  = 3;
   localparam int unsigned YEAR_DAY_W = 9;

   // Calendar constants.
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd2;
   localparam int unsigned REFORM_LAST_DAY    = 577737;
   localparam int unsigned REFORM_YEAR        = 1582;
   localparam int unsigned REFORM_SKIP        = 10;
   localparam int unsigned JULIAN_OFFSET      = 12;
   localparam int unsigned DAYS_PER_YEAR      = 365;
   localparam int unsigned WEEK_OFFSET        = 5;
   localparam int unsigned WEEK_DAYS          = 7;

   // Division by 25 as a multiply by a scaled reciprocal. Exact for
   // dividends below 2^20, which covers every supported year width.
   localparam int unsigned RECIP_W     = 20;
   localparam int unsigned RECIP_25    = 671089;
   localparam int unsigned RECIP_SHIFT = 24;

   // Width of the octal digit sum used for the weekday.
   localparam int unsigned DIGIT_SUM_W = 8;

   // Number of registered stages from an accepted request to its response strobe.
   localparam int unsigned PIPE_DEPTH = 6;

   // Control bits that travel with every pipeline stage.
   typedef struct packed {
      logic valid;
      logic ok;
   } ctl_type;

   // Days before the first of each month in a common year.
   function automatic logic [YEAR_DAY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [YEAR_DAY_W-1:0] s;
      unique case (m)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // Length of each month in a common year.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] l;
      unique case (m)
         4'd1:                                    l = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:                 l = 5'd30;
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: l = 5'd31;
         default:                                 l = 5'd0;
      endcase
      return l;
   endfunction

endpackage

FILE: design/d2dn_front.sv
// ----------------------------------------------------------------------------
// d2dn_front
// First pipeline stage: month table lookup, range checks on the request,
// and the multiplications for (year - 1) * 365 and the divisions by 25.
// ----------------------------------------------------------------------------
module d2dn_front #(
   parameter int unsigned YEAR_WIDTH = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [YEAR_WIDTH-1:0]              year,
   input  logic [d2dn_pkg::MONTH_W-1:0]       month_index,
   input  logic [d2dn_pkg::DAY_W-1:0]         day_of_month,
   output d2dn_pkg::ctl_type                  ctl_out,
   output logic [YEAR_WIDTH-1:0]              year_out,
   output logic [YEAR_WIDTH+8:0]              p365_out,
   output logic [YEAR_WIDTH-3:0]              pquarter_out,
   output logic [YEAR_WIDTH+d2dn_pkg::RECIP_W-3:0] prod_p_out,
   output logic [YEAR_WIDTH+d2dn_pkg::RECIP_W-3:0] prod_y_out,
   output logic [d2dn_pkg::YEAR_DAY_W-1:0]    mstart_out,
   output logic [d2dn_pkg::DAY_W-1:0]         mlen_out,
   output logic                               feb_out,
   output logic                               late_month_out,
   output logic                               year_early_out,
   output logic                               past_reform_out,
   output logic [d2dn_pkg::DAY_W-1:0]         day_out
);

   localparam int unsigned YW     = YEAR_WIDTH;
   localparam int unsigned QIN_W  = YW - 2;
   localparam int unsigned PROD_W = QIN_W + d2dn_pkg::RECIP_W;
   localparam int unsigned NW     = YW + 9;

   localparam logic [NW-1:0]     DAYS_YEAR = NW'(d2dn_pkg::DAYS_PER_YEAR);
   localparam logic [PROD_W-1:0] RECIP     = PROD_W'(d2dn_pkg::RECIP_25);
   localparam logic [YW-1:0]     REFORM_Y  = YW'(d2dn_pkg::REFORM_YEAR);

   logic              valid_ff, valid_in;
   logic              ok_ff, ok_in;
   logic [YW-1:0]     prev_year;
   logic [YW-1:0]     year_ff;
   logic [NW-1:0]     p365_ff, p365_in;
   logic [QIN_W-1:0]  pquarter_ff;
   logic [PROD_W-1:0] prod_p_ff, prod_p_in;
   logic [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic [d2dn_pkg::YEAR_DAY_W-1:0] mstart_ff;
   logic [d2dn_pkg::DAY_W-1:0]      mlen_ff;
   logic              feb_ff, late_month_ff, year_early_ff, past_reform_ff;
   logic [d2dn_pkg::DAY_W-1:0]      day_ff;

   // Elapsed whole years, the range checks and the products.
   always_comb begin
      prev_year = year - YW'(1);
      valid_in  = in_valid;
      ok_in     = (year != '0) && (month_index <= d2dn_pkg::MONTH_LAST) &&
                  (day_of_month != '0);
      p365_in   = NW'(prev_year) * DAYS_YEAR;
      prod_p_in = PROD_W'(prev_year[YW-1:2]) * RECIP;
      prod_y_in = PROD_W'(year[YW-1:2]) * RECIP;
   end

   // Stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      ok_ff          <= ok_in;
      year_ff        <= year;
      p365_ff        <= p365_in;
      pquarter_ff    <= prev_year[YW-1:2];
      prod_p_ff      <= prod_p_in;
      prod_y_ff      <= prod_y_in;
      mstart_ff      <= d2dn_pkg::month_start(month_index);
      mlen_ff        <= d2dn_pkg::month_len(month_index);
      feb_ff         <= (month_index == d2dn_pkg::MONTH_FEB);
      late_month_ff  <= (month_index >= d2dn_pkg::MONTH_MAR);
      year_early_ff  <= (year < REFORM_Y);
      past_reform_ff <= (prev_year > REFORM_Y);
      day_ff         <= day_of_month;
   end

   assign ctl_out         = '{valid: valid_ff, ok: ok_ff};
   assign year_out        = year_ff;
   assign p365_out        = p365_ff;
   assign pquarter_out    = pquarter_ff;
   assign prod_p_out      = prod_p_ff;
   assign prod_y_out      = prod_y_ff;
   assign mstart_out      = mstart_ff;
   assign mlen_out        = mlen_ff;
   assign feb_out         = feb_ff;
   assign late_month_out  = late_month_ff;
   assign year_early_out  = year_early_ff;
   assign past_reform_out = past_reform_ff;
   assign day_out         = day_ff;

endmodule

FILE: design/d2dn_count.sv
// ----------------------------------------------------------------------------
// d2dn_count
// Stages two to four: leap year decision and day check, the year base
// count, the day count and the reform correction with the day of year.
// ----------------------------------------------------------------------------
module d2dn_count #(
   parameter int unsigned YEAR_WIDTH = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  d2dn_pkg::ctl_type                  ctl_in,
   input  logic [YEAR_WIDTH-1:0]              year,
   input  logic [YEAR_WIDTH+8:0]              p365,
   input  logic [YEAR_WIDTH-3:0]              pquarter,
   input  logic [YEAR_WIDTH+d2dn_pkg::RECIP_W-3:0] prod_p,
   input  logic [YEAR_WIDTH+d2dn_pkg::RECIP_W-3:0] prod_y,
   input  logic [d2dn_pkg::YEAR_DAY_W-1:0]    mstart,
   input  logic [d2dn_pkg::DAY_W-1:0]         mlen,
   input  logic                               feb,
   input  logic                               late_month,
   input  logic                               year_early,
   input  logic                               past_reform,
   input  logic [d2dn_pkg::DAY_W-1:0]         day,
   output d2dn_pkg::ctl_type                  ctl_out,
   output logic [YEAR_WIDTH+8:0]              count_out,
   output logic [d2dn_pkg::YEAR_DAY_W-1:0]    year_day_out
);

   localparam int unsigned YW    = YEAR_WIDTH;
   localparam int unsigned QIN_W = YW - 2;
   localparam int unsigned QW    = YW - 6;
   localparam int unsigned NW    = YW + 9;
   localparam int unsigned YDW   = d2dn_pkg::YEAR_DAY_W;

   localparam logic [NW-1:0]  JULIAN_FIX = NW'(d2dn_pkg::JULIAN_OFFSET);
   localparam logic [NW-1:0]  LAST_DAY   = NW'(d2dn_pkg::REFORM_LAST_DAY);
   localparam logic [NW-1:0]  SKIP_N     = NW'(d2dn_pkg::REFORM_SKIP);
   localparam logic [YDW-1:0] SKIP_YD    = YDW'(d2dn_pkg::REFORM_SKIP);

   // Stage two signals.
   logic [QW-1:0]    qy, qp;
   logic [QIN_W-1:0] qy_x25;
   logic             by4, cent, quad_cent, leap;
   logic [d2dn_pkg::DAY_W:0] max_day;
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_ok_ff, s2_ok_in;
   logic [NW-1:0]    s2_base_ff, s2_base_in;
   logic [YDW-1:0]   s2_offset_ff, s2_offset_in;

   // Stage three signals.
   logic             s3_valid_ff;
   logic             s3_ok_ff;
   logic [NW-1:0]    s3_count_ff, s3_count_in;
   logic [NW-1:0]    s3_first_ff, s3_first_in;
   logic [YDW-1:0]   s3_offset_ff;

   // Stage four signals.
   logic             late_n, late_f;
   logic             s4_valid_ff;
   logic             s4_ok_ff;
   logic [NW-1:0]    s4_count_ff, s4_count_in;
   logic [YDW-1:0]   s4_yd_ff, s4_yd_in;

   // Quotients by 100 from the reciprocal products, then the leap rule.
   // A year is a century year when its quarter is a multiple of 25.
   always_comb begin
      qy        = prod_y[d2dn_pkg::RECIP_SHIFT +: QW];
      qp        = prod_p[d2dn_pkg::RECIP_SHIFT +: QW];
      qy_x25    = {qy, 4'b0000} + QIN_W'({qy, 3'b000}) + QIN_W'(qy);
      by4       = (year[1:0] == 2'b00);
      cent      = by4 && (qy_x25 == year[YW-1:2]);
      quad_cent = cent && (qy[1:0] == 2'b00);
      leap      = by4 && (year_early || !cent || quad_cent);
      max_day   = {1'b0, mlen} + (d2dn_pkg::DAY_W+1)'(feb && leap);
   end

   // Year base count with the Gregorian century terms, and the offset
   // of the day within its year.
   always_comb begin
      s2_valid_in  = ctl_in.valid;
      s2_ok_in     = ctl_in.ok && ({1'b0, day} <= max_day);
      s2_base_in   = p365 + NW'(pquarter);
      if (past_reform) begin
         s2_base_in = s2_base_in + NW'(qp >> 2) + JULIAN_FIX - NW'(qp);
      end
      s2_offset_in = mstart + YDW'(late_month && leap) + YDW'(day);
   end

   // Raw day count of the date and of the first of its year.
   always_comb begin
      s3_count_in = s2_base_ff + NW'(s2_offset_ff);
      s3_first_in = s2_base_ff + NW'(1);
   end

   // Reform correction of both counts; the day of year follows from the
   // difference of the two corrections.
   always_comb begin
      late_n      = (s3_count_ff > LAST_DAY);
      late_f      = (s3_first_ff > LAST_DAY);
      s4_count_in = late_n ? (s3_count_ff - SKIP_N) : s3_count_ff;
      s4_yd_in    = s3_offset_ff;
      if (late_n) begin
         s4_yd_in = s4_yd_in - SKIP_YD;
      end
      if (late_f) begin
         s4_yd_in = s4_yd_in + SKIP_YD;
      end
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload of the three stages.
   always_ff @(posedge clock) begin
      s2_ok_ff     <= s2_ok_in;
      s2_base_ff   <= s2_base_in;
      s2_offset_ff <= s2_offset_in;
      s3_ok_ff     <= s2_ok_ff;
      s3_count_ff  <= s3_count_in;
      s3_first_ff  <= s3_first_in;
      s3_offset_ff <= s2_offset_ff;
      s4_ok_ff     <= s3_ok_ff;
      s4_count_ff  <= s4_count_in;
      s4_yd_ff     <= s4_yd_in;
   end

   assign ctl_out      = '{valid: s4_valid_ff, ok: s4_ok_ff};
   assign count_out    = s4_count_ff;
   assign year_day_out = s4_yd_ff;

endmodule

FILE: design/d2dn_week.sv
// ----------------------------------------------------------------------------
// d2dn_week
// Stages five and six: weekday from the day count through an octal digit
// sum (eight is one modulo seven), and the registered response.
// ----------------------------------------------------------------------------
module d2dn_week #(
   parameter int unsigned YEAR_WIDTH = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  d2dn_pkg::ctl_type                 ctl_in,
   input  logic [YEAR_WIDTH+8:0]             count,
   input  logic [d2dn_pkg::YEAR_DAY_W-1:0]   year_day,
   output logic                              rsp_strobe,
   output logic                              rsp_date_ok,
   output logic [d2dn_pkg::COUNT_W-1:0]      rsp_day_count,
   output logic [d2dn_pkg::WEEKDAY_W-1:0]    rsp_weekday,
   output logic [d2dn_pkg::YEAR_DAY_W-1:0]   rsp_year_day
);

   localparam int unsigned NW   = YEAR_WIDTH + 9;
   localparam int unsigned NDIG = (NW + 2) / 3;
   localparam int unsigned SW   = d2dn_pkg::DIGIT_SUM_W;
   localparam int unsigned WW   = d2dn_pkg::WEEKDAY_W;
   localparam int unsigned CW   = d2dn_pkg::COUNT_W;
   localparam int unsigned YDW  = d2dn_pkg::YEAR_DAY_W;

   localparam logic [WW-1:0] WDAYS  = WW'(d2dn_pkg::WEEK_DAYS);
   localparam logic [WW-1:0] WSHIFT = WW'(d2dn_pkg::WEEK_OFFSET);

   // Stage five signals.
   logic [NDIG*3-1:0] padded;
   logic [SW-1:0]     s5_sum_ff, s5_sum_in;
   logic              s5_valid_ff;
   logic              s5_ok_ff;
   logic [CW-1:0]     s5_count_ff;
   logic [YDW-1:0]    s5_yd_ff;

   // Stage six signals.
   logic [4:0]        fold1;
   logic [3:0]        fold2;
   logic [WW-1:0]     rem7;
   logic [WW:0]       shifted;
   logic [WW-1:0]     wday;
   logic              strobe_ff;
   logic              ok_ff;
   logic [CW-1:0]     count_ff;
   logic [WW-1:0]     wday_ff;
   logic [YDW-1:0]    yd_ff;

   // Sum of the octal digits of the count keeps its value modulo seven.
   always_comb begin
      padded    = (NDIG*3)'(count);
      s5_sum_in = '0;
      for (int i = 0; i < NDIG; i++) begin
         s5_sum_in = s5_sum_in + SW'(padded[3*i +: 3]);
      end
   end

   // Fold the digit sum down to a remainder, then shift the week so that
   // zero is Sunday.
   always_comb begin
      fold1   = 5'(s5_sum_ff[7:6]) + 5'(s5_sum_ff[5:3]) + 5'(s5_sum_ff[2:0]);
      fold2   = 4'(fold1[4:3]) + 4'(fold1[2:0]);
      rem7    = (fold2 >= 4'(WDAYS)) ? WW'(fold2 - 4'(WDAYS)) : WW'(fold2);
      shifted = (WW+1)'(rem7) + (WW+1)'(WSHIFT);
      wday    = (shifted >= (WW+1)'(WDAYS)) ? WW'(shifted - (WW+1)'(WDAYS))
                                             : WW'(shifted);
   end

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         s5_valid_ff <= ctl_in.valid;
         strobe_ff   <= s5_valid_ff;
      end
   end

   // Payload; an invalid date gives all zero fields.
   always_ff @(posedge clock) begin
      s5_ok_ff    <= ctl_in.ok;
      s5_sum_ff   <= s5_sum_in;
      s5_count_ff <= CW'(count);
      s5_yd_ff    <= year_day;
      ok_ff       <= s5_ok_ff;
      count_ff    <= s5_ok_ff ? s5_count_ff : '0;
      wday_ff     <= s5_ok_ff ? wday : '0;
      yd_ff       <= s5_ok_ff ? s5_yd_ff : '0;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_date_ok   = ok_ff;
   assign rsp_day_count = count_ff;
   assign rsp_weekday   = wday_ff;
   assign rsp_year_day  = yd_ff;

endmodule

FILE: design/date_to_day_number.sv
// ----------------------------------------------------------------------------
// date_to_day_number
// Converts a calendar date to its day count since 1 January AD 1, with a
// validity flag, the weekday and the day of year.
// ----------------------------------------------------------------------------
// The block takes one date in every clock cycle while busy is low and answers
// each one in order with a one-cycle rsp_strobe; it has no flow control on
// the response side, so the receiver must take every beat as it comes.
// The pipeline stages, in order, are: table lookup and the multiplies,
// the leap decision with the year base count, the raw day count, the
// calendar reform correction, the weekday digit sum, and the output
// register. busy is high only while reset is held and in the cycle after.
// Invalid dates come back with rsp_date_ok low and all other fields zero.
// ----------------------------------------------------------------------------
module date_to_day_number #(
   parameter int unsigned YEAR_WIDTH = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [YEAR_WIDTH-1:0]             req_year,
   input  logic [d2dn_pkg::MONTH_W-1:0]      req_month_index,
   input  logic [d2dn_pkg::DAY_W-1:0]        req_day_of_month,
   output logic                              rsp_strobe,
   output logic                              rsp_date_ok,
   output logic [d2dn_pkg::COUNT_W-1:0]      rsp_day_count,
   output logic [d2dn_pkg::WEEKDAY_W-1:0]    rsp_weekday,
   output logic [d2dn_pkg::YEAR_DAY_W-1:0]   rsp_year_day
);

   localparam int unsigned YW     = YEAR_WIDTH;
   localparam int unsigned PROD_W = YW - 2 + d2dn_pkg::RECIP_W;
   localparam int unsigned NW     = YW + 9;

   logic                busy_ff, busy_in;
   logic                accept;

   d2dn_pkg::ctl_type   front_ctl;
   logic [YW-1:0]       front_year;
   logic [NW-1:0]       front_p365;
   logic [YW-3:0]       front_pquarter;
   logic [PROD_W-1:0]   front_prod_p;
   logic [PROD_W-1:0]   front_prod_y;
   logic [d2dn_pkg::YEAR_DAY_W-1:0] front_mstart;
   logic [d2dn_pkg::DAY_W-1:0]      front_mlen;
   logic                front_feb;
   logic                front_late_month;
   logic                front_year_early;
   logic                front_past_reform;
   logic [d2dn_pkg::DAY_W-1:0]      front_day;

   d2dn_pkg::ctl_type   count_ctl;
   logic [NW-1:0]       count_value;
   logic [d2dn_pkg::YEAR_DAY_W-1:0] count_year_day;

   // Busy holds off requests while the pipeline valid bits are cleared.
   assign busy_in = 1'b0;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Stage one.
   d2dn_front #(
      .YEAR_WIDTH (YEAR_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .year            (req_year),
      .month_index     (req_month_index),
      .day_of_month    (req_day_of_month),
      .ctl_out         (front_ctl),
      .year_out        (front_year),
      .p365_out        (front_p365),
      .pquarter_out    (front_pquarter),
      .prod_p_out      (front_prod_p),
      .prod_y_out      (front_prod_y),
      .mstart_out      (front_mstart),
      .mlen_out        (front_mlen),
      .feb_out         (front_feb),
      .late_month_out  (front_late_month),
      .year_early_out  (front_year_early),
      .past_reform_out (front_past_reform),
      .day_out         (front_day)
   );

   // Stages two to four.
   d2dn_count #(
      .YEAR_WIDTH (YEAR_WIDTH)
   ) u_count (
      .clock        (clock),
      .reset        (reset),
      .ctl_in       (front_ctl),
      .year         (front_year),
      .p365         (front_p365),
      .pquarter     (front_pquarter),
      .prod_p       (front_prod_p),
      .prod_y       (front_prod_y),
      .mstart       (front_mstart),
      .mlen         (front_mlen),
      .feb          (front_feb),
      .late_month   (front_late_month),
      .year_early   (front_year_early),
      .past_reform  (front_past_reform),
      .day          (front_day),
      .ctl_out      (count_ctl),
      .count_out    (count_value),
      .year_day_out (count_year_day)
   );

   // Stages five and six.
   d2dn_week #(
      .YEAR_WIDTH (YEAR_WIDTH)
   ) u_week (
      .clock         (clock),
      .reset         (reset),
      .ctl_in        (count_ctl),
      .count         (count_value),
      .year_day      (count_year_day),
      .rsp_strobe    (rsp_strobe),
      .rsp_date_ok   (rsp_date_ok),
      .rsp_day_count (rsp_day_count),
      .rsp_weekday   (rsp_weekday),
      .rsp_year_day  (rsp_year_day)
   );

   // Every response beat goes back to a request taken at the input and carried
   // through every pipeline stage.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, d2dn_pkg::PIPE_DEPTH))
      else $error("response beat without a matching request");

   // A rejected date carries only zeros.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_date_ok) |->
         (rsp_day_count == '0) && (rsp_weekday == '0) && (rsp_year_day == '0))
      else $error("invalid date with nonzero fields");

   // A valid date has a weekday below seven and a day of year in 1 to 366.
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_date_ok) |->
         (rsp_weekday < 3'd7) && (rsp_year_day != '0) && (rsp_year_day <= 9'd366))
      else $error("weekday or day of year out of range");

endmodule

FILE: tb/tb_date_to_day_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_to_day_number
// Self-checking testbench for the date to day number converter. A short
// table of hand-picked dates walks the field extremes, the invalid cases,
// the leap rules on both sides of 1582 and the calendar reform gap. A long
// random run follows, mostly well-formed dates with some noise and some
// broken day numbers. Every response beat is checked field by field against
// an in-order queue filled by a local calendar predictor or pinned table answers.
// ----------------------------------------------------------------------------
module tb_date_to_day_number;

   localparam int unsigned YEAR_W       = 14;
   localparam int unsigned YEAR_MAX     = (1 << YEAR_W) - 1;
   localparam int unsigned RANDOM_DATES = 1400;
   localparam int unsigned CALM_TAIL    = 150;
   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned NUM_DIRECTED = 24;

   typedef enum logic [d2dn_pkg::MONTH_W-1:0] {
      JAN, FEB, MAR, APR, MAY, JUN, JUL, AUG, SEP, OCT, NOV, DEC
   } month_type;

   typedef struct packed {
      logic                            ok;
      logic [d2dn_pkg::COUNT_W-1:0]    count;
      logic [d2dn_pkg::WEEKDAY_W-1:0]  weekday;
      logic [d2dn_pkg::YEAR_DAY_W-1:0] year_day;
   } day_info_type;

   // A directed row carries its own answer only when pinned is set.
   typedef struct {
      logic [YEAR_W-1:0]            year;
      logic [d2dn_pkg::MONTH_W-1:0] month;
      logic [d2dn_pkg::DAY_W-1:0]   day;
      bit                           pinned;
      day_info_type                 info;
   } date_row_type;

   localparam day_info_type INVALID_DATE = '0;
   localparam day_info_type FIRST_DAY    = '{1'b1, 23'd1, 3'd6, 9'd1};

   // Calendar tables for a common year.
   localparam int unsigned CUM_DAYS[12] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };
   localparam int unsigned MONTH_DAYS[12] = '{
      31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [YEAR_W-1:0]                 req_year = '0;
   logic [d2dn_pkg::MONTH_W-1:0]      req_month_index = '0;
   logic [d2dn_pkg::DAY_W-1:0]        req_day_of_month = '0;
   logic                              rsp_strobe;
   logic                              rsp_date_ok;
   logic [d2dn_pkg::COUNT_W-1:0]      rsp_day_count;
   logic [d2dn_pkg::WEEKDAY_W-1:0]    rsp_weekday;
   logic [d2dn_pkg::YEAR_DAY_W-1:0]   rsp_year_day;

   day_info_type pending_days[$];
   int unsigned  errors = 0;
   int unsigned  cycle_count = 0;

   // Dates that exercise the edges of the calendar.
   date_row_type directed_dates[NUM_DIRECTED] = '{
      '{14'd1,     JAN,   5'd1,  1'b1, FIRST_DAY},
      '{14'd0,     JAN,   5'd1,  1'b1, INVALID_DATE},
      '{14'd2000,  4'd12, 5'd1,  1'b1, INVALID_DATE},
      '{14'd2000,  4'd15, 5'd31, 1'b1, INVALID_DATE},
      '{14'd2000,  MAR,   5'd0,  1'b1, INVALID_DATE},
      '{14'd2001,  APR,   5'd31, 1'b1, INVALID_DATE},
      '{14'd1900,  FEB,   5'd29, 1'b1, INVALID_DATE},
      '{14'd2000,  FEB,   5'd30, 1'b1, INVALID_DATE},
      '{14'd1581,  FEB,   5'd29, 1'b1, INVALID_DATE},
      '{14'd1500,  FEB,   5'd29, 1'b0, INVALID_DATE},
      '{14'd2000,  FEB,   5'd29, 1'b0, INVALID_DATE},
      '{14'd1584,  FEB,   5'd29, 1'b0, INVALID_DATE},
      '{14'd1581,  DEC,   5'd31, 1'b0, INVALID_DATE},
      '{14'd1582,  OCT,   5'd4,  1'b0, INVALID_DATE},
      '{14'd1582,  OCT,   5'd5,  1'b0, INVALID_DATE},
      '{14'd1582,  OCT,   5'd14, 1'b0, INVALID_DATE},
      '{14'd1582,  OCT,   5'd15, 1'b0, INVALID_DATE},
      '{14'd1582,  DEC,   5'd31, 1'b0, INVALID_DATE},
      '{14'd1583,  JAN,   5'd1,  1'b0, INVALID_DATE},
      '{14'd1,     DEC,   5'd31, 1'b0, INVALID_DATE},
      '{14'd8192,  JUL,   5'd31, 1'b0, INVALID_DATE},
      '{14'd16383, JAN,   5'd1,  1'b0, INVALID_DATE},
      '{14'd16383, DEC,   5'd31, 1'b0, INVALID_DATE},
      '{14'd16383, 4'd15, 5'd31, 1'b1, INVALID_DATE}
   };

   date_to_day_number #(
      .YEAR_WIDTH(YEAR_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_year         (req_year),
      .req_month_index  (req_month_index),
      .req_day_of_month (req_day_of_month),
      .rsp_strobe       (rsp_strobe),
      .rsp_date_ok      (rsp_date_ok),
      .rsp_day_count    (rsp_day_count),
      .rsp_weekday      (rsp_weekday),
      .rsp_year_day     (rsp_year_day)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Julian rule before the reform year, Gregorian from it on.
   function automatic bit leap_year(int unsigned y);
      if (y % 4 != 0) return 1'b0;
      if (y < d2dn_pkg::REFORM_YEAR) return 1'b1;
      if (y % 100 != 0) return 1'b1;
      return (y % 400) == 0;
   endfunction

   function automatic int unsigned month_days(int unsigned y, int unsigned m);
      return MONTH_DAYS[m] + ((m == d2dn_pkg::MONTH_FEB && leap_year(y)) ? 1 : 0);
   endfunction

   // Raw count from 1 January AD 1, with the ten-day reform drop.
   function automatic longint unsigned count_from_epoch(int unsigned y, int unsigned m,
                                                        int unsigned d);
      longint unsigned prior;
      longint unsigned n;
      prior = 64'(y - 1);
      n = prior * d2dn_pkg::DAYS_PER_YEAR + prior / 4;
      if (prior > d2dn_pkg::REFORM_YEAR) begin
         n = n - prior / 100 + prior / 400 + d2dn_pkg::JULIAN_OFFSET;
      end
      n += CUM_DAYS[m];
      if (m >= d2dn_pkg::MONTH_MAR && leap_year(y)) n += 1;
      n += d;
      if (n > d2dn_pkg::REFORM_LAST_DAY) n -= d2dn_pkg::REFORM_SKIP;
      return n;
   endfunction

   function automatic day_info_type predict_day_info(int unsigned y, int unsigned m,
                                                     int unsigned d);
      day_info_type    r;
      longint unsigned n;
      longint unsigned first;
      r = INVALID_DATE;
      if (y == 0 || m > d2dn_pkg::MONTH_LAST || d == 0) return r;
      if (d > month_days(y, m)) return r;
      n = count_from_epoch(y, m, d);
      first = count_from_epoch(y, 32'(JAN), 1);
      r.ok = 1'b1;
      r.count = n[d2dn_pkg::COUNT_W-1:0];
      r.weekday = d2dn_pkg::WEEKDAY_W'(((n % d2dn_pkg::WEEK_DAYS) + d2dn_pkg::WEEK_OFFSET)
                                       % d2dn_pkg::WEEK_DAYS);
      r.year_day = d2dn_pkg::YEAR_DAY_W'(n - first + 1);
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Present one request beat and hold it until the block takes it.
   task automatic issue_date(logic [YEAR_W-1:0] y, logic [d2dn_pkg::MONTH_W-1:0] m,
                             logic [d2dn_pkg::DAY_W-1:0] d, day_info_type want);
      req_year <= y;
      req_month_index <= m;
      req_day_of_month <= d;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_days.push_back(want);
   endtask

   // Random sender gap with start low, taken now and then when allowed.
   task automatic sender_gap(bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Response checker: every strobe must match the oldest pending date.
   always @(posedge clock) begin
      day_info_type want;
      if (!reset && rsp_strobe) begin
         if (pending_days.size() == 0) begin
            $display("%0t: response beat with nothing pending, actual ok=%0b count=%0d",
                     $time, rsp_date_ok, rsp_day_count);
            errors++;
         end else begin
            want = pending_days.pop_front();
            check_field("date_ok", 64'(want.ok), 64'(rsp_date_ok));
            check_field("day_count", 64'(want.count), 64'(rsp_day_count));
            check_field("weekday", 64'(want.weekday), 64'(rsp_weekday));
            check_field("year_day", 64'(want.year_day), 64'(rsp_year_day));
         end
      end
   end

   // Watchdog against a hung handshake or lost responses.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned  y;
      int unsigned  m;
      int unsigned  d;
      bit           gaps_on;
      date_row_type row;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_dates[i]) begin
         row = directed_dates[i];
         issue_date(row.year, row.month, row.day,
                    row.pinned ? row.info
                               : predict_day_info(32'(row.year), 32'(row.month),
                                                  32'(row.day)));
         sender_gap(i % 2 == 1);
      end

      // Random dates, mostly well formed, with noise and broken days mixed in.
      gaps_on = 1'b1;
      for (int i = 0; i < RANDOM_DATES; i++) begin
         if (i % 100 == 0) gaps_on = $urandom_range(0, 1);
         if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 4))
               0: y = $urandom_range(1, YEAR_MAX);
               1: y = $urandom_range(1570, 1600);
               2: y = 100 * $urandom_range(1, YEAR_MAX / 100);
               3: y = $urandom_range(1, 2500);
               default: y = d2dn_pkg::REFORM_YEAR;
            endcase
            m = $urandom_range(JAN, DEC);
            d = ($urandom_range(0, 3) == 0) ? month_days(y, m)
                                            : $urandom_range(1, month_days(y, m));
         end else begin
            y = $urandom_range(0, YEAR_MAX);
            m = $urandom_range(0, (1 << d2dn_pkg::MONTH_W) - 1);
            d = $urandom_range(0, (1 << d2dn_pkg::DAY_W) - 1);
            if (m <= d2dn_pkg::MONTH_LAST && $urandom_range(0, 1) == 1) begin
               d = month_days(y, m) + 1;
            end
         end
         issue_date(YEAR_W'(y), d2dn_pkg::MONTH_W'(m), d2dn_pkg::DAY_W'(d),
                    predict_day_info(y, m, d));

         // Drain the pipeline once mid-run, otherwise insert random gaps.
         if (i == RANDOM_DATES / 2) begin
            start <= 1'b0;
            while (pending_days.size() != 0) @(posedge clock);
         end else begin
            sender_gap(gaps_on && i < RANDOM_DATES - CALM_TAIL);
         end
      end
      start <= 1'b0;

      // Let every response come back, then watch for stray beats.
      while (pending_days.size() != 0) @(posedge clock);
      repeat (d2dn_pkg::PIPE_DEPTH + 4) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: date_to_day_number.f
design/d2dn_pkg.sv
design/d2dn_front.sv
design/d2dn_count.sv
design/d2dn_week.sv
design/date_to_day_number.sv
tb/tb_date_to_day_number.sv
